### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gnsdm_pkg.sv
// Shared types and constants for the board distance map block.
// No dependencies; used by gnsdm_ctrl, gnsdm_dp and the top level.
`timescale 1ns / 1ps
package gnsdm_pkg;

   localparam int OP_W    = 2;
   localparam int ROW_W   = 4;
   localparam int COL_W   = 4;
   localparam int COUNT_W = 8;
   localparam int DIST_W  = 5;

   localparam logic [OP_W-1:0] OP_PLACE   = 2'd0;
   localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

   localparam logic [DIST_W-1:0]  DIST_MAX      = 5'd31;
   localparam logic [DIST_W-1:0]  DIST_OCCUPIED = 5'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

   // read address select
   localparam int RD_SEL_W = 2;
   localparam logic [RD_SEL_W-1:0] RD_CELL = 2'd0;
   localparam logic [RD_SEL_W-1:0] RD_REQ  = 2'd1;
   localparam logic [RD_SEL_W-1:0] RD_SRC  = 2'd2;

   // write modes
   localparam int WR_MODE_W = 3;
   localparam logic [WR_MODE_W-1:0] WR_NONE    = 3'd0;
   localparam logic [WR_MODE_W-1:0] WR_ZERO    = 3'd1;
   localparam logic [WR_MODE_W-1:0] WR_PLACE   = 3'd2;
   localparam logic [WR_MODE_W-1:0] WR_DESTROY = 3'd3;
   localparam logic [WR_MODE_W-1:0] WR_INIT    = 3'd4;
   localparam logic [WR_MODE_W-1:0] WR_MERGE   = 3'd5;

   // occupant counter operations
   localparam int CNT_OP_W = 2;
   localparam logic [CNT_OP_W-1:0] CNT_HOLD = 2'd0;
   localparam logic [CNT_OP_W-1:0] CNT_INC  = 2'd1;
   localparam logic [CNT_OP_W-1:0] CNT_DEC  = 2'd2;
   localparam logic [CNT_OP_W-1:0] CNT_CLR  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } gnsdm_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] occupant_count;
      logic [DIST_W-1:0]  cell_distance;
      logic               cell_occupied;
      logic               cell_destroyed;
   } gnsdm_rsp_type;

   // one board cell as stored in the RAM
   typedef struct packed {
      logic              destroyed;
      logic              occupied;
      logic [DIST_W-1:0] distance;
   } gnsdm_cell_type;

   typedef struct packed {
      logic                 accept;
      logic                 cell_clr;
      logic                 cell_inc;
      logic                 src_clr;
      logic                 src_inc;
      logic                 rd_en;
      logic [RD_SEL_W-1:0]  rd_sel;
      logic [WR_MODE_W-1:0] wr_mode;
      logic [CNT_OP_W-1:0]  cnt_op;
      logic                 rsp_load;
   } gnsdm_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] in_op;
      logic            in_addr_ok;
      logic            cell_last;
      logic            src_last;
      logic            rd_occupied;
   } gnsdm_status_type;

endpackage

### rtl/core/gnsdm_stream_if.sv
// Valid/ready channel carrying one payload item.
// Payload type is set per instance, from gnsdm_pkg.
`timescale 1ns / 1ps
interface gnsdm_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/gnsdm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gnsdm_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/gnsdm_ctrl.sv
// Sequencer for the board distance map: walks the RAM sweeps for each op.
// Uses gnsdm_pkg command/status types; drives gnsdm_dp.
`timescale 1ns / 1ps
module gnsdm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  gnsdm_pkg::gnsdm_status_type status,
   output gnsdm_pkg::gnsdm_cmd_type    cmd
);
   import gnsdm_pkg::*;

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_BOOT    = 5'd0;
   localparam logic [ST_W-1:0] S_IDLE    = 5'd1;
   localparam logic [ST_W-1:0] S_CLR     = 5'd2;
   localparam logic [ST_W-1:0] S_PL_RD   = 5'd3;
   localparam logic [ST_W-1:0] S_PL_WR   = 5'd4;
   localparam logic [ST_W-1:0] S_MG_RD   = 5'd5;
   localparam logic [ST_W-1:0] S_MG_WR   = 5'd6;
   localparam logic [ST_W-1:0] S_DS_RD   = 5'd7;
   localparam logic [ST_W-1:0] S_DS_WR   = 5'd8;
   localparam logic [ST_W-1:0] S_IN_RD   = 5'd9;
   localparam logic [ST_W-1:0] S_IN_WR   = 5'd10;
   localparam logic [ST_W-1:0] S_SR_RD   = 5'd11;
   localparam logic [ST_W-1:0] S_SR_CHK  = 5'd12;
   localparam logic [ST_W-1:0] S_RB_RD   = 5'd13;
   localparam logic [ST_W-1:0] S_RB_WR   = 5'd14;
   localparam logic [ST_W-1:0] S_RSP_RD  = 5'd15;
   localparam logic [ST_W-1:0] S_RSP_CAP = 5'd16;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_BOOT: begin
            cmd.wr_mode  = WR_ZERO;
            cmd.cell_inc = 1'b1;
            if (status.cell_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept   = 1'b1;
               cmd.cell_clr = 1'b1;
               case (status.in_op)
                  OP_CLEAR:   state_in = S_CLR;
                  OP_PLACE:   state_in = status.in_addr_ok ? S_PL_RD : S_RSP_RD;
                  OP_DESTROY: state_in = status.in_addr_ok ? S_DS_RD : S_RSP_RD;
                  default:    state_in = S_RSP_RD;
               endcase
            end
         end
         S_CLR: begin
            cmd.wr_mode  = WR_ZERO;
            cmd.cell_inc = 1'b1;
            cmd.cnt_op   = CNT_CLR;
            if (status.cell_last) state_in = S_RSP_RD;
         end
         S_PL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REQ;
            state_in   = S_PL_WR;
         end
         S_PL_WR: begin
            cmd.wr_mode = WR_PLACE;
            cmd.cnt_op  = CNT_INC;
            state_in    = S_MG_RD;
         end
         S_MG_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CELL;
            state_in   = S_MG_WR;
         end
         S_MG_WR: begin
            cmd.wr_mode  = WR_MERGE;
            cmd.cell_inc = 1'b1;
            state_in     = status.cell_last ? S_RSP_RD : S_MG_RD;
         end
         S_DS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REQ;
            state_in   = S_DS_WR;
         end
         S_DS_WR: begin
            cmd.wr_mode = WR_DESTROY;
            if (status.rd_occupied) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_IN_RD;
            end else begin
               state_in = S_RSP_RD;
            end
         end
         S_IN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CELL;
            state_in   = S_IN_WR;
         end
         S_IN_WR: begin
            cmd.wr_mode  = WR_INIT;
            cmd.cell_inc = 1'b1;
            if (status.cell_last) begin
               cmd.src_clr = 1'b1;
               state_in    = S_SR_RD;
            end else begin
               state_in = S_IN_RD;
            end
         end
         S_SR_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SRC;
            state_in   = S_SR_CHK;
         end
         S_SR_CHK: begin
            if (status.rd_occupied) begin
               cmd.cell_clr = 1'b1;
               state_in     = S_RB_RD;
            end else if (status.src_last) begin
               state_in = S_RSP_RD;
            end else begin
               cmd.src_inc = 1'b1;
               state_in    = S_SR_RD;
            end
         end
         S_RB_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CELL;
            state_in   = S_RB_WR;
         end
         S_RB_WR: begin
            cmd.wr_mode  = WR_MERGE;
            cmd.cell_inc = 1'b1;
            if (!status.cell_last) begin
               state_in = S_RB_RD;
            end else if (status.src_last) begin
               state_in = S_RSP_RD;
            end else begin
               cmd.src_inc = 1'b1;
               state_in    = S_SR_RD;
            end
         end
         S_RSP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_REQ;
            state_in   = S_RSP_CAP;
         end
         S_RSP_CAP: begin
            // wait here only while the previous result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_BOOT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### rtl/core/gnsdm_dp.sv
// Datapath: cell RAM, cell and source walkers, distance unit, counter, result register.
// Uses gnsdm_pkg and gnsdm_ram; steered by gnsdm_ctrl.
`timescale 1ns / 1ps
module gnsdm_dp #(
   parameter int ROWS = 10,
   parameter int COLS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gnsdm_pkg::gnsdm_cmd_type    cmd,
   input  gnsdm_pkg::gnsdm_req_type    in_req,
   output gnsdm_pkg::gnsdm_status_type status,
   output gnsdm_pkg::gnsdm_rsp_type    out_rsp
);
   import gnsdm_pkg::*;

   localparam int CELLS  = ROWS * COLS;
   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int AW     = $clog2(CELLS);
   localparam int DW     = ((RW > CW) ? RW : CW) + 1;
   localparam int CELL_W = $bits(gnsdm_cell_type);

   logic [AW-1:0]      req_addr_ff;
   logic               addr_ok_ff;
   logic [RW-1:0]      cell_r_ff, cell_r_in, src_r_ff, src_r_in;
   logic [CW-1:0]      cell_c_ff, cell_c_in, src_c_ff, src_c_in;
   logic [AW-1:0]      cell_addr_ff, cell_addr_in, src_addr_ff, src_addr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   gnsdm_rsp_type      rsp_ff;

   logic               in_addr_ok;
   logic [AW-1:0]      in_addr;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   logic [CELL_W-1:0]  ram_rd_data;
   gnsdm_cell_type     rd_word, wr_word;
   logic [RW-1:0]      dr;
   logic [CW-1:0]      dc;
   logic [DW-1:0]      dsum;
   logic [DIST_W-1:0]  new_dist;

   assign in_addr_ok = (32'(in_req.row) < 32'(ROWS)) && (32'(in_req.col) < 32'(COLS));
   assign in_addr    = AW'(32'(in_req.row) * 32'(COLS) + 32'(in_req.col));

   // cell walker: row, column and linear address move together
   always_comb begin
      cell_r_in    = cell_r_ff;
      cell_c_in    = cell_c_ff;
      cell_addr_in = cell_addr_ff;
      if (cmd.cell_clr) begin
         cell_r_in    = '0;
         cell_c_in    = '0;
         cell_addr_in = '0;
      end else if (cmd.cell_inc) begin
         cell_addr_in = cell_addr_ff + 1'b1;
         if (cell_c_ff == CW'(COLS - 1)) begin
            cell_c_in = '0;
            cell_r_in = cell_r_ff + 1'b1;
         end else begin
            cell_c_in = cell_c_ff + 1'b1;
         end
      end
   end

   // source walker, loaded with the addressed cell whenever a request is accepted
   always_comb begin
      src_r_in    = src_r_ff;
      src_c_in    = src_c_ff;
      src_addr_in = src_addr_ff;
      if (cmd.accept) begin
         src_r_in    = RW'(in_req.row);
         src_c_in    = CW'(in_req.col);
         src_addr_in = in_addr;
      end else if (cmd.src_clr) begin
         src_r_in    = '0;
         src_c_in    = '0;
         src_addr_in = '0;
      end else if (cmd.src_inc) begin
         src_addr_in = src_addr_ff + 1'b1;
         if (src_c_ff == CW'(COLS - 1)) begin
            src_c_in = '0;
            src_r_in = src_r_ff + 1'b1;
         end else begin
            src_c_in = src_c_ff + 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      case (cmd.cnt_op)
         CNT_INC: if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
         CNT_DEC: if (count_ff != '0) count_in = count_ff - 1'b1;
         CNT_CLR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_REQ:  rd_addr = req_addr_ff;
         RD_SRC:  rd_addr = src_addr_ff;
         default: rd_addr = cell_addr_ff;
      endcase
   end

   assign rd_word = gnsdm_cell_type'(ram_rd_data);

   // Manhattan distance from the current source, saturated
   assign dr       = (cell_r_ff > src_r_ff) ? cell_r_ff - src_r_ff : src_r_ff - cell_r_ff;
   assign dc       = (cell_c_ff > src_c_ff) ? cell_c_ff - src_c_ff : src_c_ff - cell_c_ff;
   assign dsum     = DW'(dr) + DW'(dc);
   assign new_dist = (32'(dsum) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsum);

   always_comb begin
      wr_word = rd_word;
      case (cmd.wr_mode)
         WR_ZERO: wr_word = '0;
         WR_PLACE: begin
            wr_word.occupied = 1'b1;
            wr_word.distance = DIST_OCCUPIED;
         end
         WR_DESTROY: begin
            wr_word.destroyed = 1'b1;
            wr_word.occupied  = 1'b0;
         end
         WR_INIT: wr_word.distance = rd_word.occupied ? DIST_OCCUPIED : '0;
         WR_MERGE: begin
            // zero means no occupant seen yet; occupied cells keep their 1
            if (!rd_word.occupied &&
                (rd_word.distance == '0 || rd_word.distance > new_dist)) begin
               wr_word.distance = new_dist;
            end
         end
         default: wr_word = rd_word;
      endcase
   end

   assign wr_en   = (cmd.wr_mode != WR_NONE);
   assign wr_addr = (cmd.wr_mode == WR_PLACE || cmd.wr_mode == WR_DESTROY) ?
                    req_addr_ff : cell_addr_ff;

   gnsdm_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (CELL_W'(wr_word)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_r_ff    <= '0;
         cell_c_ff    <= '0;
         cell_addr_ff <= '0;
         count_ff     <= '0;
      end else begin
         cell_r_ff    <= cell_r_in;
         cell_c_ff    <= cell_c_in;
         cell_addr_ff <= cell_addr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      src_r_ff    <= src_r_in;
      src_c_ff    <= src_c_in;
      src_addr_ff <= src_addr_in;
      if (cmd.accept) begin
         req_addr_ff <= in_addr;
         addr_ok_ff  <= in_addr_ok;
      end
      if (cmd.rsp_load) begin
         rsp_ff.occupant_count <= count_ff;
         rsp_ff.cell_distance  <= addr_ok_ff ? rd_word.distance : '0;
         rsp_ff.cell_occupied  <= addr_ok_ff && rd_word.occupied;
         rsp_ff.cell_destroyed <= addr_ok_ff && rd_word.destroyed;
      end
   end

   assign status.in_op       = in_req.op;
   assign status.in_addr_ok  = in_addr_ok;
   assign status.cell_last   = (cell_addr_ff == AW'(CELLS - 1));
   assign status.src_last    = (src_addr_ff == AW'(CELLS - 1));
   assign status.rd_occupied = rd_word.occupied;

   assign out_rsp = rsp_ff;
endmodule

### rtl/core/grid_nearest_ship_distance_map.sv
// Top level of the board distance map: controller, datapath and channels.
// Depends on gnsdm_pkg, gnsdm_stream_if, gnsdm_ctrl, gnsdm_dp, assert_macros.svh.
//
// Keeps a ROWS x COLS board of occupied/destroyed marks and a Manhattan
// distance to the nearest occupied cell (occupied cells read 1, an empty board 0).
// req_bus takes one item {op, row, col}: place, destroy, clear or query.
// rsp_bus returns one item per request: occupant count and the addressed cell.
// Cells live in one RAM word each; the place and destroy sweeps read and then
// write each cell, while the clear sweep only writes. Work per item: a query or
// an off-board address only reads the cell; place marks the cell and merges its
// distance into every cell; clear zeroes every cell and the count; destroy marks
// the cell and, if it was occupied, resets every distance and merges again from
// each remaining occupied cell.
// One item is worked at a time; a new item is taken once the previous one is
// finished, even while its result still waits on a stalled receiver.
// The result register holds until rsp ready; a following item finishes its
// work and then waits for that register before loading.
// Reset runs a clearing pass over every RAM cell with req ready low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grid_nearest_ship_distance_map #(
   parameter int ROWS = 10,
   parameter int COLS = 10
) (
   input logic            clock,
   input logic            reset,
   gnsdm_stream_if.sink   req_bus,
   gnsdm_stream_if.source rsp_bus
);
   import gnsdm_pkg::*;

   gnsdm_cmd_type    cmd;
   gnsdm_status_type status;
   gnsdm_rsp_type    rsp_data;

   // sequencer: owns the handshakes, the state and the result valid
   gnsdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: RAM, walkers, distance unit, counter and result payload
   gnsdm_dp #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .in_req  (req_bus.payload),
      .status  (status),
      .out_rsp (rsp_data)
   );

   assign rsp_bus.payload = rsp_data;

   // an accepted item keeps the block busy for at least the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "request taken while busy")
   // RAM writes only happen outside idle: in the reset clearing pass or while an item is in work
   `ASSERT_IMPLIES(a_write_busy, clock, reset, cmd.wr_mode != WR_NONE, !req_bus.ready, "RAM write while idle")
   // an occupied cell always carries distance one
   `ASSERT_IMPLIES(a_occ_dist, clock, reset, rsp_bus.valid && rsp_bus.payload.cell_occupied, rsp_bus.payload.cell_distance == DIST_OCCUPIED, "occupied cell distance not one")
endmodule
